[rtl/segc_pkg.sv]
package segc_pkg;

  localparam int CODE_W     = 8;
  localparam int GAIN_W     = 24;
  localparam int NUM_CODES  = 256;
  localparam int NUM_THR    = 255;
  localparam int NUM_LANES  = 3;
  // lane: lookup, multiply, one stage per code bit; plus the output register
  localparam int LANE_STAGES = 2 + CODE_W;
  localparam int PIPE_STAGES = LANE_STAGES + 1;
  localparam int BN_W       = 512;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

  // Elaboration-time helpers for the transfer-curve tables.
  function automatic logic [BN_W-1:0] bn_pow(logic [63:0] base, int e);
    logic [BN_W-1:0] r;
    r = BN_W'(1);
    for (int i = 0; i < e; i++) begin
      r = r * BN_W'(base);
    end
    return r;
  endfunction

  // {exact, floor((n/d)^(12/5) * 2^bits)} for n <= d
  function automatic logic [64:0] curve_floor(logic [63:0] n, logic [63:0] d, int bits);
    logic [BN_W-1:0] d12;
    logic [BN_W-1:0] rhs;
    logic [BN_W-1:0] lhs;
    logic [63:0]     lo;
    logic [63:0]     hi;
    logic [63:0]     mid;
    d12 = bn_pow(d, 12);
    rhs = bn_pow(n, 12) << (5 * bits);
    lo  = 64'd0;
    hi  = 64'd1 << bits;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      lhs = bn_pow(mid, 5) * d12;
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    lhs = bn_pow(lo, 5) * d12;
    return {(lhs == rhs), lo};
  endfunction

  // linear value of code c, round half up, lfb fraction bits
  function automatic logic [63:0] lin_entry(int c, int lfb);
    logic [63:0] num;
    logic [64:0] cf;
    if (c <= 10) begin
      num = (64'd5 * 64'(c)) << (lfb + 1);
      return ((num / 64'd16473) + 64'd1) >> 1;
    end else begin
      cf = curve_floor(64'd1000 * 64'(c) + 64'd14025, 64'd269025, lfb + 1);
      return (cf[63:0] + 64'd1) >> 1;
    end
  endfunction

  // linear value of the midpoint between codes k and k+1, ceiling, fb fraction bits
  function automatic logic [63:0] thr_entry(int k, int fb);
    logic [63:0] num;
    logic [64:0] cf;
    if (k <= 9) begin
      num = (64'd5 * (64'd2 * 64'(k) + 64'd1)) << fb;
      return (num + 64'd32945) / 64'd32946;
    end else begin
      cf = curve_floor(64'd100 * (64'd2 * 64'(k) + 64'd1) + 64'd2805, 64'd53805, fb);
      return cf[64] ? cf[63:0] : cf[63:0] + 64'd1;
    end
  endfunction

endpackage

[rtl/segc_in_if.sv]
interface segc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;

  modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                  input ready);
  modport sink (input valid, input chan0_in, input chan1_in, input chan2_in,
                output ready);
endinterface

[rtl/segc_out_if.sv]
interface segc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_out;
  logic [7:0] chan1_out;
  logic [7:0] chan2_out;

  modport source (output valid, output chan0_out, output chan1_out, output chan2_out,
                  input ready);
  modport sink (input valid, input chan0_out, input chan1_out, input chan2_out,
                output ready);
endinterface

[rtl/segc_cfg_if.sv]
interface segc_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] gain_scale;

  modport source (output valid, output gain_scale, input ready);
  modport sink (input valid, input gain_scale, output ready);
endinterface

[rtl/segc_lane.sv]
module segc_lane import segc_pkg::*; #(
  parameter int LINEAR_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic [LANE_STAGES-1:0] adv_i,
  input  logic [CODE_W-1:0]      code_i,
  input  logic [GAIN_W-1:0]      gain_i,
  output logic [CODE_W-1:0]      code_o
);

  localparam int LIN_W  = LINEAR_FRAC_BITS + 1;
  localparam int PROD_W = LIN_W + GAIN_W;
  localparam int THR_W  = LINEAR_FRAC_BITS + GAIN_FRAC_BITS + 1;

  typedef logic [NUM_CODES-1:0][LIN_W-1:0] lin_tab_t;
  typedef logic [NUM_THR-1:0][THR_W-1:0]   thr_tab_t;

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    for (int c = 0; c < NUM_CODES; c++) begin
      t[c] = LIN_W'(lin_entry(c, LINEAR_FRAC_BITS));
    end
    return t;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    for (int k = 0; k < NUM_THR; k++) begin
      t[k] = THR_W'(thr_entry(k, LINEAR_FRAC_BITS + GAIN_FRAC_BITS));
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam thr_tab_t THR_TAB = build_thr();

  logic [LIN_W-1:0]  lin_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] srch_p_q [CODE_W-1];
  logic [CODE_W-1:0] srch_n_q [CODE_W];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      lin_q <= LIN_TAB[code_i];
    end
    if (adv_i[1]) begin
      prod_q <= PROD_W'(lin_q) * PROD_W'(gain_i);
    end
  end

  // Binary search over the monotonic midpoint table, MSB of the code first.
  for (genvar j = 0; j < CODE_W; j++) begin : g_srch
    logic [PROD_W-1:0] p_in;
    logic [CODE_W-1:0] n_in;
    logic [CODE_W-1:0] cand;
    logic [CODE_W-1:0] idx;
    logic [CODE_W-1:0] n_d;

    if (j == 0) begin : g_first
      assign p_in = prod_q;
      assign n_in = '0;
    end else begin : g_next
      assign p_in = srch_p_q[j-1];
      assign n_in = srch_n_q[j-1];
    end

    always_comb begin
      cand = n_in | (CODE_W'(1) << (CODE_W - 1 - j));
      idx  = cand - CODE_W'(1);
      n_d  = (p_in >= PROD_W'(THR_TAB[idx])) ? cand : n_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[2+j]) begin
        srch_n_q[j] <= n_d;
      end
    end

    if (j < CODE_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i[2+j]) begin
          srch_p_q[j] <= p_in;
        end
      end
    end
  end

  assign code_o = srch_n_q[CODE_W-1];

endmodule

[rtl/segc_ctrl.sv]
module segc_ctrl import segc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PIPE_STAGES-1:0] adv_o
);

  logic [PIPE_STAGES-1:0] valid_q;
  logic [PIPE_STAGES-1:0] valid_d;

  // a stage moves on when it is empty or the one after it moves on
  always_comb begin
    adv_o[PIPE_STAGES-1] = !valid_q[PIPE_STAGES-1] || out_ready_i;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      adv_o[i] = !valid_q[i] || adv_o[i+1];
    end
    valid_d[0] = adv_o[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < PIPE_STAGES; i++) begin
      if (adv_o[i]) begin
        valid_d[i] = valid_q[i-1];
      end else begin
        valid_d[i] = valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv_o[0];
  assign out_valid_o = valid_q[PIPE_STAGES-1];

endmodule

[rtl/srgb_exposure_gain_correction.sv]
// sRGB exposure gain correction. Each 8-bit channel of a pixel is linearised
// through the sRGB inverse curve, multiplied by gain_scale (unsigned, with
// GAIN_FRAC_BITS fraction bits, reset value 65536) and re-encoded to the nearest
// 8-bit sRGB code, ties rounding up and saturating at 255. Three identical lanes
// handle the three channels side by side and the output register merges them into
// one result transaction. Throughput is one pixel per clock while pix_o.ready
// is not held low. Each pixel passes through the table lookup, the multiply,
// eight binary-search stages over the midpoint table and the output register.
// A stalled output fills the pipeline before input ready drops. Write gain_scale
// only while no pixel is in flight; the write channel is always ready.
module srgb_exposure_gain_correction import segc_pkg::*; #(
  parameter int LINEAR_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  segc_in_if.sink    pix_i,
  segc_out_if.source pix_o,
  segc_cfg_if.sink   cfg_i
);

  logic [GAIN_W-1:0]      gain_q;
  logic [PIPE_STAGES-1:0] adv;
  logic [CODE_W-1:0]      lane_in  [NUM_LANES];
  logic [CODE_W-1:0]      lane_out [NUM_LANES];
  logic [CODE_W-1:0]      chan_q   [NUM_LANES];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      gain_q <= cfg_i.gain_scale;
    end
  end

  segc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .adv_o       (adv)
  );

  assign lane_in[0] = pix_i.chan0_in;
  assign lane_in[1] = pix_i.chan1_in;
  assign lane_in[2] = pix_i.chan2_in;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    segc_lane #(
      .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS),
      .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv[LANE_STAGES-1:0]),
      .code_i (lane_in[l]),
      .gain_i (gain_q),
      .code_o (lane_out[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv[PIPE_STAGES-1]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        chan_q[l] <= lane_out[l];
      end
    end
  end

  assign pix_o.chan0_out = chan_q[0];
  assign pix_o.chan1_out = chan_q[1];
  assign pix_o.chan2_out = chan_q[2];

endmodule

[tb/sv/tb.sv]
module tb import segc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIN_FB     = 16;
  localparam int GAIN_FB    = 16;
  localparam int LATENCY    = 11;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 450;
  localparam int PHASES     = 8;
  localparam int REPORT_MAX = 10;
  localparam int NUM_ROWS   = 23;

  // lane 0 is chan0; written as {chan2, chan1, chan0}
  typedef logic [NUM_LANES-1:0][CODE_W-1:0] pixel_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    pixel_t            pix;
    logic              known;
    pixel_t            res;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  segc_in_if  pix_if ();
  segc_out_if res_if ();
  segc_cfg_if cfg_if ();

  srgb_exposure_gain_correction #(
    .LINEAR_FRAC_BITS(LIN_FB),
    .GAIN_FRAC_BITS  (GAIN_FB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .pix_o (res_if),
    .cfg_i (cfg_if)
  );

  // Predictor state
  logic [LIN_FB:0]     lin_lut [NUM_CODES];
  logic [63:0]         mid_lut [NUM_THR];
  logic [GAIN_W-1:0]   gain_now;
  pixel_t              graded_q [$];

  int fail_cnt;
  int result_cnt;
  int idle_cycles;
  int rcv_stall;
  int rcv_calm;
  bit sender_calm;

  // Gain, pixel in, typed result where it is obvious
  plan_row_t dir_rows [NUM_ROWS] = '{
    '{24'h010000, 24'h00FF00, 1'b1, 24'h00FF00},
    '{24'h010000, 24'hFF00FF, 1'b1, 24'hFF00FF},
    '{24'h010000, 24'h7FFE01, 1'b0, 24'h000000},
    '{24'h010000, 24'h0C0B0A, 1'b0, 24'h000000},
    '{24'h010000, 24'h050403, 1'b0, 24'h000000},
    '{24'h000000, 24'hFFFFFF, 1'b1, 24'h000000},
    '{24'h000000, 24'h0155AA, 1'b1, 24'h000000},
    '{24'h000001, 24'hFFFFFF, 1'b1, 24'h000000},
    '{24'h000001, 24'hC88000, 1'b1, 24'h000000},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{24'hFFFFFF, 24'h000000, 1'b1, 24'h000000},
    '{24'hFFFFFF, 24'h0A0201, 1'b0, 24'h000000},
    '{24'hFFFFFF, 24'h7F800B, 1'b0, 24'h000000},
    '{24'h020000, 24'hFEC8FF, 1'b1, 24'hFFFFFF},
    '{24'h020000, 24'h204080, 1'b0, 24'h000000},
    '{24'h800000, 24'h80FF00, 1'b1, 24'hFFFF00},
    '{24'h800000, 24'h030201, 1'b0, 24'h000000},
    '{24'h008000, 24'hAA55FF, 1'b0, 24'h000000},
    '{24'h00FFFF, 24'h80FEFF, 1'b0, 24'h000000},
    '{24'h010001, 24'h33F00F, 1'b0, 24'h000000},
    '{24'h010000, 24'h040201, 1'b0, 24'h000000},
    '{24'h010000, 24'h201008, 1'b0, 24'h000000},
    '{24'h010000, 24'hFE8040, 1'b0, 24'h000000}
  };

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [511:0] raise_big(logic [63:0] base, int e);
    logic [511:0] acc;
    acc = 512'd1;
    repeat (e) acc = acc * 512'(base);
    return acc;
  endfunction

  // {exact, floor((n/d)^2.4 * 2^fb)}: float estimate, then trimmed with exact integers
  function automatic logic [64:0] curve_scaled(logic [63:0] n, logic [63:0] d, int fb);
    logic [511:0] d12;
    logic [511:0] rhs;
    logic [63:0]  f;
    real          approx;
    d12    = raise_big(d, 12);
    rhs    = raise_big(n, 12) << (5 * fb);
    approx = $pow(real'(n) / real'(d), 2.4) * $pow(2.0, real'(fb));
    f      = 64'(longint'(approx));
    while (raise_big(f + 64'd1, 5) * d12 <= rhs) f = f + 64'd1;
    while (raise_big(f, 5) * d12 > rhs) f = f - 64'd1;
    return {(raise_big(f, 5) * d12 == rhs), f};
  endfunction

  function automatic pixel_t regrade_pixel(pixel_t pix, logic [GAIN_W-1:0] gain);
    pixel_t      res;
    logic [63:0] prod;
    int          n;
    for (int ch = 0; ch < NUM_LANES; ch++) begin
      prod = 64'(lin_lut[pix[ch]]) * 64'(gain);
      n = 0;
      // ties reach the threshold, so exact midpoints round up
      for (int k = 0; k < NUM_THR; k++) begin
        if (prod >= mid_lut[k]) n++;
      end
      res[ch] = CODE_W'(n);
    end
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t pix;
    for (int ch = 0; ch < NUM_LANES; ch++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(5))
          0: pix[ch] = 8'd0;
          1: pix[ch] = 8'd1;
          2: pix[ch] = 8'd10;
          3: pix[ch] = 8'd11;
          4: pix[ch] = 8'd254;
          default: pix[ch] = 8'd255;
        endcase
      end else begin
        pix[ch] = CODE_W'($urandom_range(255));
      end
    end
    return pix;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(4))
      0: return GAIN_W'(32'h10000 + $urandom_range(8191) - 4096);
      1: return GAIN_W'($urandom_range(16384, 262143));
      2: return GAIN_W'($urandom);
      3: return GAIN_W'($urandom_range(1, 65535));
      default: return GAIN_W'($urandom_range(262144, 16777215));
    endcase
  endfunction

  task automatic send_pixel(pixel_t pix, logic known, pixel_t typed);
    int gap;
    pix_if.valid    <= 1'b1;
    pix_if.chan0_in <= pix[0];
    pix_if.chan1_in <= pix[1];
    pix_if.chan2_in <= pix[2];
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    graded_q = {graded_q, (known ? typed : regrade_pixel(pix, gain_now))};
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender off until the pipe is empty
  task automatic drain_pipe();
    pix_if.valid <= 1'b0;
    while (graded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    cfg_if.valid      <= 1'b1;
    cfg_if.gain_scale <= g;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    gain_now = g;
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: checking and back-pressure
  always @(posedge clk_i) begin : result_side
    pixel_t got;
    pixel_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = {res_if.chan2_out, res_if.chan1_out, res_if.chan0_out};
        if (graded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("%0t: unexpected result transaction %h", $realtime, got);
          end
        end else begin
          want = graded_q.pop_front();
          for (int ch = 0; ch < NUM_LANES; ch++) begin
            if (got[ch] !== want[ch]) begin
              fail_cnt++;
              if (fail_cnt <= REPORT_MAX) begin
                $display("%0t: result %0d chan%0d: expected %0d, got %0d", $realtime,
                         result_cnt, ch, want[ch], got[ch]);
              end
            end
          end
        end
        result_cnt++;
      end
      if (rcv_stall > 0) begin
        res_if.ready <= 1'b0;
        rcv_stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (rcv_calm > 0) begin
          rcv_calm--;
        end else begin
          rcv_stall = gap_len();
          if ($urandom_range(39) == 0) rcv_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("srgb_exposure_gain_correction test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [64:0] cf;
    logic [63:0] num;
    rst_ni            = 1'b0;
    pix_if.valid      = 1'b0;
    pix_if.chan0_in   = '0;
    pix_if.chan1_in   = '0;
    pix_if.chan2_in   = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.gain_scale = '0;
    fail_cnt          = 0;
    result_cnt        = 0;
    idle_cycles       = 0;
    rcv_stall         = 0;
    rcv_calm          = 0;
    sender_calm       = 1'b0;

    // Linear table, round half up; the low codes sit on the straight segment
    for (int c = 0; c < NUM_CODES; c++) begin
      if (c <= 10) begin
        num = (64'd5 * 64'(c)) << (LIN_FB + 1);
        lin_lut[c] = (LIN_FB + 1)'(((num / 64'd16473) + 64'd1) >> 1);
      end else begin
        cf = curve_scaled(64'd1000 * 64'(c) + 64'd14025, 64'd269025, LIN_FB + 1);
        lin_lut[c] = (LIN_FB + 1)'((cf[63:0] + 64'd1) >> 1);
      end
    end
    // Midpoint thresholds in the product domain, ceiling
    for (int k = 0; k < NUM_THR; k++) begin
      if (k <= 9) begin
        num = (64'd5 * (64'd2 * 64'(k) + 64'd1)) << (LIN_FB + GAIN_FB);
        mid_lut[k] = (num + 64'd32945) / 64'd32946;
      end else begin
        cf = curve_scaled(64'd100 * (64'd2 * 64'(k) + 64'd1) + 64'd2805, 64'd53805,
                          LIN_FB + GAIN_FB);
        mid_lut[k] = cf[64] ? cf[63:0] : cf[63:0] + 64'd1;
      end
    end
    gain_now = GAIN_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].gain != gain_now) begin
        drain_pipe();
        write_gain(dir_rows[i].gain);
        sender_calm = ($urandom_range(2) == 0);
      end
      send_pixel(dir_rows[i].pix, dir_rows[i].known, dir_rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_pipe();
      write_gain(random_gain());
      sender_calm = ($urandom_range(3) == 0);
      repeat (RAND_ITEMS / PHASES) send_pixel(random_pixel(), 1'b0, '0);
    end

    drain_pipe();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (graded_q.size() != 0) begin
      fail_cnt += graded_q.size();
      $display("%0d expected results never arrived", graded_q.size());
    end
    if (fail_cnt == 0) begin
      $display("srgb_exposure_gain_correction test passed");
    end else begin
      $display("srgb_exposure_gain_correction test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/segc_pkg.sv
rtl/segc_in_if.sv
rtl/segc_out_if.sv
rtl/segc_cfg_if.sv
rtl/segc_lane.sv
rtl/segc_ctrl.sv
rtl/srgb_exposure_gain_correction.sv
tb/sv/tb.sv
